// File: sv/selective_repeat_send_window_assert.svh
// Assertion macros for the selective-repeat send window.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_ASSERT_SVH

// same-cycle implication
`define SRSW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srsw assertion failed");

// next-cycle implication
`define SRSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsw assertion failed");

`endif

// File: sv/srsw_pkg.sv
// Shared types and constants of the selective-repeat send window.
// No dependencies.
`default_nettype none

package srsw_pkg;

    localparam int NUM_W   = 32;
    localparam int WIN_W   = 8;
    localparam int LIM_W   = 9;
    localparam int USAGE_W = 8;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_ADV   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic start;
        logic shift;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic adv_done;
    } stat_t;

endpackage

`default_nettype wire

// File: sv/srsw_in_if.sv
// Input item channel of the send window.
// Depends on srsw_pkg.
`default_nettype none

interface srsw_in_if
    import srsw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [NUM_W-1:0] ack_number;

    modport source (output valid, output opcode, output ack_number, input ready);
    modport sink (input valid, input opcode, input ack_number, output ready);
endinterface

`default_nettype wire

// File: sv/srsw_out_if.sv
// Result item channel of the send window.
// Depends on srsw_pkg.
`default_nettype none

interface srsw_out_if
    import srsw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               status;
    logic               can_send;
    logic [USAGE_W-1:0] usage;
    logic [NUM_W-1:0]   next_number;
    logic [NUM_W-1:0]   base_number;
    logic [7:0]         advanced_count;

    modport source (output valid, output status, output can_send, output usage,
                    output next_number, output base_number, output advanced_count,
                    input ready);
    modport sink (input valid, input status, input can_send, input usage,
                  input next_number, input base_number, input advanced_count,
                  output ready);
endinterface

`default_nettype wire

// File: sv/srsw_cfg_if.sv
// Configuration write channel (window limit) of the send window.
// Depends on srsw_pkg.
`default_nettype none

interface srsw_cfg_if
    import srsw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/srsw_ctrl.sv
// Sequencing controller: accept, advance loop, result publish.
// Depends on srsw_pkg.
`default_nettype none

module srsw_ctrl
    import srsw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_opcode,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_PUB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.start   = (state_reg == ST_IDLE) && in_valid;
        cmd.shift   = (state_reg == ST_ADV) && !stat.adv_done;
        cmd.publish = (state_reg == ST_PUB) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op_t'(in_opcode) == OP_ADV) ? ST_ADV : ST_PUB;
                end
            end
            ST_ADV:
            begin
                if (stat.adv_done)
                begin
                    state_next = ST_PUB;
                end
            end
            ST_PUB:
            begin
                if (cmd.publish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/srsw_dp.sv
// Datapath: counts, ack bitmap, window register and result registers.
// Depends on srsw_pkg.
`default_nettype none

module srsw_dp
    import srsw_pkg::*;
#(
    parameter int MAX_WINDOW = 128
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [1:0]         in_opcode,
    input  wire logic [NUM_W-1:0]   in_ack_number,
    input  wire logic               cfg_we,
    input  wire logic [WIN_W-1:0]   cfg_data,
    output logic                    out_status,
    output logic                    out_can_send,
    output logic [USAGE_W-1:0]      out_usage,
    output logic [NUM_W-1:0]        out_next_number,
    output logic [NUM_W-1:0]        out_base_number,
    output logic [7:0]              out_advanced_count
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [LIM_W-1:0] MAXW = LIM_W'(MAX_WINDOW);

    logic [MAX_WINDOW-1:0] bitmap_reg;
    logic [MAX_WINDOW-1:0] bitmap_next;
    logic [NUM_W-1:0]      base_reg;
    logic [NUM_W-1:0]      base_next;
    logic [NUM_W-1:0]      next_reg;
    logic [NUM_W-1:0]      next_next;
    logic [WIN_W-1:0]      win_reg;
    logic [LIM_W-1:0]      cnt_reg;
    logic [LIM_W-1:0]      cnt_next;
    logic                  err_reg;
    logic                  err_next;

    logic [LIM_W-1:0]      eff_win;
    logic [NUM_W-1:0]      offset;
    logic                  ack_ok;
    logic [NUM_W-1:0]      used;

    assign eff_win = ({1'b0, win_reg} > MAXW) ? MAXW : {1'b0, win_reg};
    assign offset  = in_ack_number - base_reg;
    assign ack_ok  = (in_ack_number >= base_reg) && (offset < NUM_W'(eff_win));
    assign used    = next_reg - base_reg;

    assign stat.adv_done = !bitmap_reg[0] || (cnt_reg >= eff_win);

    always_comb
    begin
        bitmap_next = bitmap_reg;
        base_next   = base_reg;
        next_next   = next_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        if (cmd.start)
        begin
            cnt_next = '0;
            err_next = 1'b0;
            case (op_t'(in_opcode))
                OP_SEND:
                begin
                    next_next = next_reg + NUM_W'(1);
                end
                OP_ACK:
                begin
                    if (ack_ok)
                    begin
                        bitmap_next[offset[IDX_W-1:0]] = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    bitmap_next = '0;
                    base_next   = '0;
                    next_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.shift)
        begin
            bitmap_next = bitmap_reg >> 1;
            base_next   = base_reg + NUM_W'(1);
            cnt_next    = cnt_reg + LIM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg <= '0;
            base_reg   <= '0;
            next_reg   <= '0;
            win_reg    <= WIN_W'(128);
            cnt_reg    <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            bitmap_reg <= bitmap_next;
            base_reg   <= base_next;
            next_reg   <= next_next;
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            if (cfg_we)
            begin
                win_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_status         <= err_reg;
            out_can_send       <= (used < NUM_W'(eff_win));
            out_usage          <= (used > NUM_W'(255)) ? USAGE_W'(255) : used[USAGE_W-1:0];
            out_next_number    <= next_reg;
            out_base_number    <= base_reg;
            out_advanced_count <= cnt_reg[7:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/selective_repeat_send_window.sv
// Top level of the selective-repeat send window: controller plus datapath.
// Depends on srsw_pkg, srsw_in_if, srsw_out_if, srsw_cfg_if, srsw_ctrl, srsw_dp.
//
//   port   dir   handshake      carries
//   in     sink  valid/ready    opcode, ack_number
//   out    src   valid/ready    status, can_send, usage, next/base number, advanced_count
//   cfg    sink  valid/ready    window limit (always ready)
//
// Send, ack and clear apply the operation, then load the result register.
// Advance shifts the bitmap one slot per cycle until its oldest slot is unacked or the limit is met.
// A new item is taken while the previous result still waits in the output register;
// the publish step stalls until that register is free.
// Reset clears the bitmap, both counts and sets the window limit to 128.
`default_nettype none

module selective_repeat_send_window
    import srsw_pkg::*;
#(
    parameter int MAX_WINDOW = 128
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    srsw_in_if.sink    in,
    srsw_out_if.source out,
    srsw_cfg_if.sink   cfg
);

    `include "selective_repeat_send_window_assert.svh"

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    srsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_opcode (in.opcode),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srsw_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_opcode          (in.opcode),
        .in_ack_number      (in.ack_number),
        .cfg_we             (cfg.valid),
        .cfg_data           (cfg.data),
        .out_status         (out.status),
        .out_can_send       (out.can_send),
        .out_usage          (out.usage),
        .out_next_number    (out.next_number),
        .out_base_number    (out.base_number),
        .out_advanced_count (out.advanced_count)
    );

    `SRSW_ASSERT_NEXT(a_one_at_a_time, in.valid && in.ready, !in.ready)
    `SRSW_ASSERT_NOW(a_start_only_idle, cmd.start, in.ready && !cmd.shift && !cmd.publish)
    `SRSW_ASSERT_NOW(a_err_no_advance, out.valid && out.status, out.advanced_count == 8'd0)
    `SRSW_ASSERT_NOW(a_adv_bounded, out.valid, 32'(out.advanced_count) <= 32'(MAX_WINDOW))

endmodule

`default_nettype wire
